// ===== rtl/core/cep_pkg.sv =====
// cep_pkg: shared constants, command codes and item types for the cursor editor
// with prefix maxima. Used by cursor_editor_prefix_max and tb_top, depends on nothing.
package cep_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned SUM_W      = 26;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // field widths of the items on the ports
  localparam int unsigned CMD_W = 3;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned POS_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] max_prefix;
    logic                    status;
  } out_item_t;

  // one entry of the left stack
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      maxv;
  } left_entry_t;

  localparam int unsigned LEFT_W = $bits(left_entry_t);

endpackage

// ===== rtl/core/cep_ram.sv =====
// cep_ram: generic single-write, single-read RAM with registered read data.
// Standalone, no package dependency.
module cep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cursor_editor_prefix_max.sv =====
// cursor_editor_prefix_max: top level, two-stack gap buffer with prefix maxima.
// Depends on cep_pkg and cep_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
// Each item is taken in S_IDLE and executed in S_EXEC: the stack reads are launched in
// the accept cycle, and the write back and count update happen in the next cycle, set
// by the registered read data of the stack RAMs. No new item is taken before then.
// A query whose result finds the output register still full waits in S_EXEC.
// Reset clears the state, counts and output valid only; stack contents are undefined until written.
module cursor_editor_prefix_max (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cep_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cep_pkg::out_item_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  cep_pkg::in_item_t            item_q;
  logic [cep_pkg::CNT_W-1:0]    lc_q, lc_d, rc_q, rc_d;
  logic                         out_valid_q, out_valid_d;
  cep_pkg::out_item_t           out_q, out_d;

  logic                         accept;
  logic [cep_pkg::ADDR_W-1:0]   l_raddr, r_raddr;
  logic [cep_pkg::CNT_W-1:0]    lc_m1, rc_m1, pos_m1;
  cep_pkg::left_entry_t         l_rdata, l_wdata;
  logic [cep_pkg::LEFT_W-1:0]   l_rdata_raw;
  logic [cep_pkg::VALUE_BITS-1:0] r_rdata, r_wdata;
  logic                         l_we, r_we;
  logic [cep_pkg::CNT_W:0]      total;
  logic                         not_full, out_free, query_ok;
  logic signed [cep_pkg::VALUE_BITS-1:0] push_v;
  logic signed [cep_pkg::SUM_W-1:0]      push_ext, new_sum, new_max;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // read addresses come from the counts, or for a query from the incoming item's position
  assign lc_m1  = lc_q - cep_pkg::CNT_W'(1);
  assign rc_m1  = rc_q - cep_pkg::CNT_W'(1);
  assign pos_m1 = cep_pkg::CNT_W'(in_data_i.position) - cep_pkg::CNT_W'(1);

  always_comb begin
    if (cep_pkg::cmd_e'(in_data_i.command) == cep_pkg::CMD_QUERY) begin
      l_raddr = pos_m1[cep_pkg::ADDR_W-1:0];
    end else begin
      l_raddr = lc_m1[cep_pkg::ADDR_W-1:0];
    end
  end
  assign r_raddr = rc_m1[cep_pkg::ADDR_W-1:0];

  assign l_rdata = cep_pkg::left_entry_t'(l_rdata_raw);

  // value pushed onto the left stack and its running sum and maximum
  always_comb begin
    if (cep_pkg::cmd_e'(item_q.command) == cep_pkg::CMD_RIGHT) begin
      push_v = r_rdata;
    end else begin
      push_v = item_q.value[cep_pkg::VALUE_BITS-1:0];
    end
  end
  assign push_ext = {{(cep_pkg::SUM_W - cep_pkg::VALUE_BITS){push_v[cep_pkg::VALUE_BITS-1]}},
                     push_v};

  always_comb begin
    if (lc_q != '0) begin
      new_sum = l_rdata.sum + push_ext;
      new_max = (new_sum > l_rdata.maxv) ? new_sum : l_rdata.maxv;
    end else begin
      new_sum = push_ext;
      new_max = push_ext;
    end
  end

  assign l_wdata.value = push_v;
  assign l_wdata.sum   = new_sum;
  assign l_wdata.maxv  = new_max;
  assign r_wdata       = l_rdata.value;

  assign total    = {1'b0, lc_q} + {1'b0, rc_q};
  assign not_full = total < (cep_pkg::CNT_W + 1)'(cep_pkg::CAPACITY);
  assign query_ok = (item_q.position != '0) &&
                    (cep_pkg::CNT_W'(item_q.position) <= lc_q);

  // execute the latched command
  always_comb begin
    state_d     = state_q;
    lc_d        = lc_q;
    rc_d        = rc_q;
    l_we        = 1'b0;
    r_we        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (cep_pkg::cmd_e'(item_q.command))
          cep_pkg::CMD_INSERT: begin
            if (not_full) begin
              l_we = 1'b1;
              lc_d = lc_q + cep_pkg::CNT_W'(1);
            end
          end
          cep_pkg::CMD_LEFT: begin
            if (lc_q != '0) begin
              r_we = 1'b1;
              lc_d = lc_m1;
              rc_d = rc_q + cep_pkg::CNT_W'(1);
            end
          end
          cep_pkg::CMD_RIGHT: begin
            if (rc_q != '0) begin
              l_we = 1'b1;
              rc_d = rc_m1;
              lc_d = lc_q + cep_pkg::CNT_W'(1);
            end
          end
          cep_pkg::CMD_DELETE: begin
            if (lc_q != '0) begin
              lc_d = lc_m1;
            end
          end
          cep_pkg::CMD_QUERY: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              if (query_ok) begin
                out_d.max_prefix = l_rdata.maxv;
                out_d.status     = 1'b0;
              end else begin
                out_d.max_prefix = '0;
                out_d.status     = 1'b1;
              end
            end else begin
              state_d = S_EXEC;
            end
          end
          cep_pkg::CMD_CLEAR: begin
            lc_d = '0;
            rc_d = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lc_q        <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      rc_q        <= rc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  // left stack: value, prefix sum, prefix maximum
  cep_ram #(
    .WIDTH (cep_pkg::LEFT_W),
    .DEPTH (cep_pkg::CAPACITY)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (lc_q[cep_pkg::ADDR_W-1:0]),
    .wdata_i (l_wdata),
    .re_i    (accept),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata_raw)
  );

  // right stack: values only
  cep_ram #(
    .WIDTH (cep_pkg::VALUE_BITS),
    .DEPTH (cep_pkg::CAPACITY)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rc_q[cep_pkg::ADDR_W-1:0]),
    .wdata_i (r_wdata),
    .re_i    (accept),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the store never holds more than its capacity
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (cep_pkg::CNT_W + 1)'(cep_pkg::CAPACITY))
    else $error("stack counts exceed capacity");

  // an accepted item is executed in the following cycle
  a_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted item not executed");

  // a finished query shows its result in the next cycle
  a_query_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cep_pkg::cmd_e'(item_q.command) == cep_pkg::CMD_QUERY &&
     out_free) |=> out_valid_o)
    else $error("query result missing");

  // stack writes only happen while executing
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_we || r_we) |-> state_q == S_EXEC)
    else $error("stack write outside execute");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for cursor_editor_prefix_max, the two-stack
// cursor editor with prefix maxima. Holds a small scoreboard class that tracks
// both stacks and the expected query answers. Depends on cep_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cep_pkg::*;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam realtime CLK_PERIOD   = 12.0;
  localparam int      RESET_CYCLES = 9;
  localparam int      IDLE_PCT     = 21;
  localparam int      RANDOM_ITEMS = 600;
  localparam int      DRAIN_CYCLES = 10;
  localparam int      REPORT_LIMIT = 10;
  localparam realtime RUN_LIMIT    = 2_000_000.0;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic [POS_W-1:0]        POS_TOP = '1;

  // tracks both stacks and queues the answer every query item should produce
  class prefix_max_scoreboard;
    longint      left_vals [CAPACITY];
    longint      left_sums [CAPACITY];
    longint      left_peaks[CAPACITY];
    longint      right_vals[CAPACITY];
    int          left_count;
    int          right_count;
    out_item_t   awaited_answers[$];
    int          bad_answers;

    function new();
      left_count  = 0;
      right_count = 0;
      bad_answers = 0;
    endfunction

    // push onto the left stack, extending running sum and running max
    function void stack_onto_left(longint v);
      longint s;
      longint m;
      s = v;
      m = v;
      if (left_count > 0) begin
        s = left_sums[left_count-1] + v;
        m = (s > left_peaks[left_count-1]) ? s : left_peaks[left_count-1];
      end
      left_vals[left_count]  = v;
      left_sums[left_count]  = s;
      left_peaks[left_count] = m;
      left_count++;
    endfunction

    // update state for one accepted item
    function void take_command(in_item_t it);
      out_item_t ans;
      longint    peak;
      int        k;
      k = int'(it.position);
      case (it.command)
        CMD_INSERT: begin
          if (left_count + right_count < CAPACITY) stack_onto_left(longint'(it.value));
        end
        CMD_LEFT: begin
          if (left_count > 0) begin
            left_count--;
            right_vals[right_count] = left_vals[left_count];
            right_count++;
          end
        end
        CMD_RIGHT: begin
          if (right_count > 0) begin
            right_count--;
            stack_onto_left(right_vals[right_count]);
          end
        end
        CMD_DELETE: begin
          if (left_count > 0) left_count--;
        end
        CMD_QUERY: begin
          if (k == 0 || k > left_count) begin
            ans.max_prefix = '0;
            ans.status     = 1'b1;
          end else begin
            peak           = left_peaks[k-1];
            ans.max_prefix = peak[SUM_W-1:0];
            ans.status     = 1'b0;
          end
          awaited_answers = {awaited_answers, ans};
        end
        CMD_CLEAR: begin
          left_count  = 0;
          right_count = 0;
        end
        default: ;
      endcase
    endfunction

    // compare one accepted answer against the oldest awaited one
    function void check_answer(out_item_t got);
      out_item_t want;
      if (awaited_answers.size() == 0) begin
        bad_answers++;
        if (bad_answers <= REPORT_LIMIT)
          $display("%0t: unexpected answer max_prefix %0d status %0b",
                   $realtime, got.max_prefix, got.status);
        return;
      end
      want = awaited_answers.pop_front();
      if (got.max_prefix !== want.max_prefix || got.status !== want.status) begin
        bad_answers++;
        if (bad_answers <= REPORT_LIMIT)
          $display("%0t: answer mismatch max_prefix exp %0d got %0d, status exp %0b got %0b",
                   $realtime, want.max_prefix, got.max_prefix, want.status, got.status);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  bit        quiet_run   = 1'b0;

  prefix_max_scoreboard sb = new();

  cursor_editor_prefix_max i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, none during quiet stretches
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // check every accepted answer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_answer(out_data_o);
  end

  // offer one item, with random idle cycles ahead of it, and wait for accept
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_command(it);
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] v,
                          input logic [POS_W-1:0] p);
    in_item_t it;
    it.command  = cmd;
    it.value    = v;
    it.position = p;
    send_item(it);
  endtask

  // mostly random values, some at the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // query lengths mostly in or just past range, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 70) return POS_W'($urandom_range(sb.left_count + 1, 0));
    if (r < 80) return POS_W'(sb.left_count);
    if (r < 85) return POS_W'(sb.left_count + 1);
    return POS_W'($urandom_range(int'(POS_TOP), 0));
  endfunction

  // stimulus
  initial begin
    int r;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty sides, extremes, moves with recompute, unused codes
    send_cmd(CMD_QUERY, '0, 0);
    send_cmd(CMD_QUERY, '0, 1);
    send_cmd(CMD_LEFT, '0, 0);
    send_cmd(CMD_RIGHT, '0, 0);
    send_cmd(CMD_DELETE, '0, 0);
    send_cmd(CMD_INSERT, VAL_MAX, 0);
    send_cmd(CMD_INSERT, VAL_MIN, POS_TOP);
    send_cmd(CMD_INSERT, '1, 0);
    send_cmd(CMD_INSERT, '0, 0);
    send_cmd(CMD_QUERY, '0, 1);
    send_cmd(CMD_QUERY, '1, 4);
    send_cmd(CMD_QUERY, '0, 5);
    send_cmd(CMD_QUERY, '0, POS_TOP);
    send_cmd(CMD_LEFT, '0, 0);
    send_cmd(CMD_LEFT, '0, 0);
    send_cmd(CMD_INSERT, 16'sd100, 0);
    send_cmd(CMD_RIGHT, '0, 0);
    send_cmd(CMD_RIGHT, '0, 0);
    send_cmd(CMD_RIGHT, '0, 0);
    send_cmd(CMD_QUERY, '0, 5);
    send_cmd(CMD_DELETE, '0, 0);
    send_cmd(CMD_UNUSED_LO, pick_value(), 3);
    send_cmd(CMD_UNUSED_HI, pick_value(), 2);
    send_cmd(CMD_QUERY, '0, 0);
    send_cmd(CMD_CLEAR, '0, 0);
    send_cmd(CMD_QUERY, '0, 1);

    // fill the store with the largest value, no idling on either side
    quiet_run = 1'b1;
    while (sb.left_count + sb.right_count < CAPACITY) begin
      if ($urandom_range(9) == 0) send_cmd(CMD_LEFT, pick_value(), pick_position());
      else send_cmd(CMD_INSERT, VAL_MAX, pick_position());
    end
    send_cmd(CMD_INSERT, VAL_MIN, 0);
    send_cmd(CMD_QUERY, '0, POS_W'(sb.left_count));
    send_cmd(CMD_QUERY, '0, POS_W'(sb.left_count + 1));
    while (sb.right_count > 0) send_cmd(CMD_RIGHT, pick_value(), 0);
    send_cmd(CMD_QUERY, '0, POS_W'(CAPACITY));
    send_cmd(CMD_QUERY, '0, POS_W'(CAPACITY + 1));
    send_cmd(CMD_INSERT, VAL_MIN, 0);
    send_cmd(CMD_DELETE, '0, 0);
    send_cmd(CMD_INSERT, VAL_MIN, 0);
    send_cmd(CMD_QUERY, '0, POS_W'(CAPACITY));
    send_cmd(CMD_QUERY, '0, POS_W'(CAPACITY - 1));
    send_cmd(CMD_CLEAR, '0, 0);
    quiet_run = 1'b0;

    // random edits and queries
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 34)      send_cmd(CMD_INSERT, pick_value(), POS_W'($urandom()));
      else if (r < 49) send_cmd(CMD_LEFT, pick_value(), POS_W'($urandom()));
      else if (r < 64) send_cmd(CMD_RIGHT, pick_value(), POS_W'($urandom()));
      else if (r < 72) send_cmd(CMD_DELETE, pick_value(), POS_W'($urandom()));
      else if (r < 95) send_cmd(CMD_QUERY, pick_value(), pick_position());
      else if (r < 97) send_cmd(CMD_CLEAR, pick_value(), POS_W'($urandom()));
      else if (r < 98) send_cmd(CMD_UNUSED_LO, pick_value(), POS_W'($urandom()));
      else             send_cmd(CMD_UNUSED_HI, pick_value(), POS_W'($urandom()));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain outstanding answers, then watch for strays
    while (sb.awaited_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.bad_answers == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
